/* design/mwm_pkg.sv */
// ----------------------------------------------------------------------------
// mwm_pkg
// shared types and constants of the maze wall map: maze size, opcodes,
// headings, register indexes and the item record passed between stages
// ----------------------------------------------------------------------------
package mwm_pkg;

    localparam int MAZE_SIZE = 16;
    localparam int CELL_W    = 4;
    localparam int SENSOR_W  = 12;
    localparam int CFG_IDX_W = 1;

    localparam logic [1:0] OP_SENSE  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [1:0] DIR_NORTH = 2'd0;
    localparam logic [1:0] DIR_EAST  = 2'd1;
    localparam logic [1:0] DIR_SOUTH = 2'd2;
    localparam logic [1:0] DIR_WEST  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_SIDE_THRESHOLD  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRONT_THRESHOLD = 1'd1;

    localparam logic [SENSOR_W-1:0] SIDE_THRESHOLD_RESET  = 12'd100;
    localparam logic [SENSOR_W-1:0] FRONT_THRESHOLD_RESET = 12'd150;

    typedef logic [MAZE_SIZE-1:0][MAZE_SIZE-1:0] bit_table_t;

    typedef struct packed {
        logic [1:0]          opcode;
        logic [CELL_W-1:0]   cell_x;
        logic [CELL_W-1:0]   cell_y;
        logic [1:0]          heading;
        logic                wall_side;
        logic                query_known;
        logic [SENSOR_W-1:0] right_reading;
        logic [SENSOR_W-1:0] center_reading;
        logic [SENSOR_W-1:0] left_reading;
    } item_t;

endpackage

/* design/mwm_in_stage.sv */
// ----------------------------------------------------------------------------
// mwm_in_stage
// input register: holds one item until the table stage takes it
// ----------------------------------------------------------------------------
module mwm_in_stage
    import mwm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    input  logic  take,
    output logic  item_valid,
    output item_t item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* design/mwm_wall_table.sv */
// ----------------------------------------------------------------------------
// mwm_wall_table
// four wall and known bit tables, with the sense / insert update and the
// single-bit query read
// ----------------------------------------------------------------------------
module mwm_wall_table
    import mwm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                update,
    input  item_t               item,
    input  logic [SENSOR_W-1:0] side_threshold,
    input  logic [SENSOR_W-1:0] front_threshold,
    output logic                answer_bit
);

    bit_table_t north_wall_reg;
    bit_table_t north_known_reg;
    bit_table_t east_wall_reg;
    bit_table_t east_known_reg;
    bit_table_t north_wall_next;
    bit_table_t north_known_next;
    bit_table_t east_wall_next;
    bit_table_t east_known_next;

    bit_table_t nw_set;
    bit_table_t nk_set;
    bit_table_t ew_set;
    bit_table_t ek_set;

    logic [2:0][1:0]        mark_dir;
    logic [2:0]             mark_hit;
    logic [2:0]             mark_en;
    logic [2:0]             mark_east;
    logic [2:0][CELL_W-1:0] mark_row;
    logic [2:0][CELL_W-1:0] mark_bit;

    logic in_range;
    logic do_write;

    assign in_range = ({1'b0, item.cell_x} < (CELL_W+1)'(MAZE_SIZE))
                   && ({1'b0, item.cell_y} < (CELL_W+1)'(MAZE_SIZE));
    assign do_write = update && in_range;

    // front, right, left
    always_comb
    begin
        mark_dir[0] = item.heading;
        mark_dir[1] = item.heading + 2'd1;
        mark_dir[2] = item.heading + 2'd3;
        mark_hit[0] = item.center_reading > front_threshold;
        mark_hit[1] = item.right_reading > side_threshold;
        mark_hit[2] = item.left_reading > side_threshold;
        for (int m = 0; m < 3; m++)
        begin
            case (mark_dir[m])
                DIR_NORTH:
                begin
                    mark_en[m]   = 1'b1;
                    mark_east[m] = 1'b0;
                    mark_row[m]  = item.cell_y;
                    mark_bit[m]  = item.cell_x;
                end
                DIR_EAST:
                begin
                    mark_en[m]   = 1'b1;
                    mark_east[m] = 1'b1;
                    mark_row[m]  = item.cell_x;
                    mark_bit[m]  = item.cell_y;
                end
                DIR_SOUTH:
                begin
                    mark_en[m]   = item.cell_y != '0;
                    mark_east[m] = 1'b0;
                    mark_row[m]  = item.cell_y - 1'b1;
                    mark_bit[m]  = item.cell_x;
                end
                default:
                begin
                    mark_en[m]   = item.cell_x != '0;
                    mark_east[m] = 1'b1;
                    mark_row[m]  = item.cell_x - 1'b1;
                    mark_bit[m]  = item.cell_y;
                end
            endcase
        end
    end

    always_comb
    begin
        nw_set = '0;
        nk_set = '0;
        ew_set = '0;
        ek_set = '0;
        if (item.opcode == OP_SENSE)
        begin
            for (int m = 0; m < 3; m++)
            begin
                if (mark_en[m])
                begin
                    if (mark_east[m])
                    begin
                        ek_set[mark_row[m]][mark_bit[m]] = 1'b1;
                        ew_set[mark_row[m]][mark_bit[m]] = mark_hit[m];
                    end
                    else
                    begin
                        nk_set[mark_row[m]][mark_bit[m]] = 1'b1;
                        nw_set[mark_row[m]][mark_bit[m]] = mark_hit[m];
                    end
                end
            end
        end
        else if (item.opcode == OP_INSERT)
        begin
            if (item.wall_side)
            begin
                ew_set[item.cell_x][item.cell_y] = 1'b1;
            end
            else
            begin
                nw_set[item.cell_y][item.cell_x] = 1'b1;
            end
        end
    end

    assign north_wall_next  = north_wall_reg  | (do_write ? nw_set : '0);
    assign north_known_next = north_known_reg | (do_write ? nk_set : '0);
    assign east_wall_next   = east_wall_reg   | (do_write ? ew_set : '0);
    assign east_known_next  = east_known_reg  | (do_write ? ek_set : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            north_wall_reg  <= '0;
            north_known_reg <= '0;
            east_wall_reg   <= '0;
            east_known_reg  <= '0;
        end
        else
        begin
            north_wall_reg  <= north_wall_next;
            north_known_reg <= north_known_next;
            east_wall_reg   <= east_wall_next;
            east_known_reg  <= east_known_next;
        end
    end

    always_comb
    begin
        answer_bit = 1'b0;
        if (in_range && item.opcode == OP_QUERY)
        begin
            if (item.wall_side)
            begin
                answer_bit = item.query_known ? east_known_reg[item.cell_x][item.cell_y]
                                              : east_wall_reg[item.cell_x][item.cell_y];
            end
            else
            begin
                answer_bit = item.query_known ? north_known_reg[item.cell_y][item.cell_x]
                                              : north_wall_reg[item.cell_y][item.cell_x];
            end
        end
    end

endmodule

/* design/mwm_out_stage.sv */
// ----------------------------------------------------------------------------
// mwm_out_stage
// result register: holds the answer until the master side takes it
// ----------------------------------------------------------------------------
module mwm_out_stage
    import mwm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic load,
    output logic load_ready,
    input  logic answer_bit,
    output logic out_valid,
    input  logic out_ready,
    output logic out_answer
);

    logic valid_reg;
    logic valid_next;
    logic answer_reg;

    assign load_ready = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            answer_reg <= answer_bit;
        end
    end

    assign out_valid  = valid_reg;
    assign out_answer = answer_reg;

endmodule

/* design/maze_wall_map_update.sv */
// ----------------------------------------------------------------------------
// maze_wall_map_update
// micromouse wall map: sense, insert and query items against wall / known
// bit tables, one answer per item
//
//   channel   dir  handshake                   payload
//   s_axis    in   s_axis_tvalid/tready        tuser opcode, tdata item fields
//   m_axis    out  m_axis_tvalid/tready        tdata answer_bit
//   cfg       in   cfg_valid/cfg_ready         cfg_index, cfg_data
//
// one item per cycle while the result side is not stalled; a transfer passes the input
// register, then the table update and result register
// reset clears all tables at once; thresholds return to 100 side, 150 front
// a stalled result holds the result register, then the input register
// ----------------------------------------------------------------------------
module maze_wall_map_update
    import mwm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [1:0]           s_axis_tuser,  // opcode
    // cell_x, cell_y, heading, wall_side, query_known,
    // right_reading, center_reading, left_reading
    input  logic [47:0]          s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,  // answer_bit, zero fill
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SENSOR_W-1:0]  cfg_data
);

    logic [SENSOR_W-1:0] side_threshold_reg;
    logic [SENSOR_W-1:0] front_threshold_reg;
    item_t               in_item;
    item_t               item;
    logic                item_valid;
    logic                out_load_ready;
    logic                advance;
    logic                answer_bit;
    logic                out_answer;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_threshold_reg  <= SIDE_THRESHOLD_RESET;
            front_threshold_reg <= FRONT_THRESHOLD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SIDE_THRESHOLD:  side_threshold_reg  <= cfg_data;
                REG_FRONT_THRESHOLD: front_threshold_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        in_item.opcode         = s_axis_tuser;
        in_item.cell_x         = s_axis_tdata[3:0];
        in_item.cell_y         = s_axis_tdata[7:4];
        in_item.heading        = s_axis_tdata[9:8];
        in_item.wall_side      = s_axis_tdata[10];
        in_item.query_known    = s_axis_tdata[11];
        in_item.right_reading  = s_axis_tdata[23:12];
        in_item.center_reading = s_axis_tdata[35:24];
        in_item.left_reading   = s_axis_tdata[47:36];
    end

    assign advance = item_valid && out_load_ready;

    mwm_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .take       (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    mwm_wall_table u_wall_table (
        .clk             (clk),
        .rst_n           (rst_n),
        .update          (advance),
        .item            (item),
        .side_threshold  (side_threshold_reg),
        .front_threshold (front_threshold_reg),
        .answer_bit      (answer_bit)
    );

    mwm_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance),
        .load_ready (out_load_ready),
        .answer_bit (answer_bit),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_answer (out_answer)
    );

    assign m_axis_tdata = {7'd0, out_answer};

    a_advance_gives_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        advance |=> m_axis_tvalid
    ) else $error("item left the input register without a result");

    a_non_query_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        advance && item.opcode != OP_QUERY |=> m_axis_tdata[0] == 1'b0
    ) else $error("non-query item produced a set answer");

    a_empty_input_ready: assert property (
        @(posedge clk) disable iff (!rst_n)
        !item_valid |-> s_axis_tready
    ) else $error("input stalled with an empty input register");

endmodule

/* tb/maze_wall_map_update_tb.sv */
// ----------------------------------------------------------------------------
// maze_wall_map_update_tb
// self-checking bench for the maze wall map: a short table of directed sense,
// insert and query items at the maze borders and at the threshold edges, then
// random item streams under several threshold settings; every answer is compared
// in order against a pinned value or a model of the four wall and known tables
// ----------------------------------------------------------------------------
module maze_wall_map_update_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import mwm_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT = 200000;

    typedef struct {
        item_t item;
        bit    pinned;
        logic  answer;
    } stim_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [1:0]           s_axis_tuser = '0;    // opcode
    // cell_x, cell_y, heading, wall_side, query_known,
    // right_reading, center_reading, left_reading
    logic [47:0]          s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;         // answer_bit, zero fill
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SENSOR_W-1:0]  cfg_data = '0;

    // model of the wall map
    bit_table_t          north_wall = '0;
    bit_table_t          east_wall = '0;
    bit_table_t          north_known = '0;
    bit_table_t          east_known = '0;
    logic [SENSOR_W-1:0] side_limit = SIDE_THRESHOLD_RESET;
    logic [SENSOR_W-1:0] front_limit = FRONT_THRESHOLD_RESET;

    stim_row_t  pinned_answers[$];
    logic [7:0] answers_due[$];
    int         mismatch_count = 0;
    int         cycle_count = 0;
    int         tx_idle_pct = 6;
    int         rx_idle_pct = 6;
    int         rx_hold_left = 0;
    logic       rx_hold_start = 1'b0;
    logic       rx_hold_done = 1'b0;

    maze_wall_map_update uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic item_t make_item(input logic [1:0] op, input int x, input int y,
                                        input logic [1:0] hd, input logic side,
                                        input logic qk, input int r, input int c,
                                        input int l);
        item_t it;
        it.opcode         = op;
        it.cell_x         = CELL_W'(x);
        it.cell_y         = CELL_W'(y);
        it.heading        = hd;
        it.wall_side      = side;
        it.query_known    = qk;
        it.right_reading  = SENSOR_W'(r);
        it.center_reading = SENSOR_W'(c);
        it.left_reading   = SENSOR_W'(l);
        return it;
    endfunction

    function automatic logic [47:0] pack_fields(input item_t it);
        return {it.left_reading, it.center_reading, it.right_reading,
                it.query_known, it.wall_side, it.heading, it.cell_y, it.cell_x};
    endfunction

    // mark one wall of the cell seen; south and west walls on the border are skipped
    function automatic void mark_seen(input logic [CELL_W-1:0] x, input logic [CELL_W-1:0] y,
                                      input logic [1:0] dir, input logic hit);
        case (dir)
            DIR_NORTH:
            begin
                north_known[y][x] = 1'b1;
                if (hit) north_wall[y][x] = 1'b1;
            end
            DIR_EAST:
            begin
                east_known[x][y] = 1'b1;
                if (hit) east_wall[x][y] = 1'b1;
            end
            DIR_SOUTH:
            begin
                if (y != 0)
                begin
                    north_known[y - 1][x] = 1'b1;
                    if (hit) north_wall[y - 1][x] = 1'b1;
                end
            end
            default:
            begin
                if (x != 0)
                begin
                    east_known[x - 1][y] = 1'b1;
                    if (hit) east_wall[x - 1][y] = 1'b1;
                end
            end
        endcase
    endfunction

    function automatic logic apply_map_item(input item_t it);
        logic [1:0] right_dir;
        logic [1:0] left_dir;
        logic       answer;
        answer    = 1'b0;
        right_dir = it.heading + 2'd1;
        left_dir  = it.heading + 2'd3;
        case (it.opcode)
            OP_SENSE:
            begin
                mark_seen(it.cell_x, it.cell_y, it.heading, it.center_reading > front_limit);
                mark_seen(it.cell_x, it.cell_y, right_dir, it.right_reading > side_limit);
                mark_seen(it.cell_x, it.cell_y, left_dir, it.left_reading > side_limit);
            end
            OP_INSERT:
            begin
                if (!it.wall_side) north_wall[it.cell_y][it.cell_x] = 1'b1;
                else east_wall[it.cell_x][it.cell_y] = 1'b1;
            end
            OP_QUERY:
            begin
                if (!it.wall_side)
                    answer = it.query_known ? north_known[it.cell_y][it.cell_x]
                                            : north_wall[it.cell_y][it.cell_x];
                else
                    answer = it.query_known ? east_known[it.cell_x][it.cell_y]
                                            : east_wall[it.cell_x][it.cell_y];
            end
            default:
            begin
            end
        endcase
        return answer;
    endfunction

    // readings cluster on the threshold edges and the range extremes
    function automatic logic [SENSOR_W-1:0] pick_reading(input logic [SENSOR_W-1:0] thr);
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return thr;
            3: return thr + 12'd1;
            4: return thr - 12'd1;
            default: return SENSOR_W'($urandom_range(4095));
        endcase
    endfunction

    function automatic item_t random_item();
        item_t it;
        int    pick;
        pick = $urandom_range(99);
        if (pick < 40) it.opcode = OP_SENSE;
        else if (pick < 60) it.opcode = OP_INSERT;
        else if (pick < 95) it.opcode = OP_QUERY;
        else it.opcode = OP_UNUSED;
        // a small corner often, so queries land on walls already touched
        if ($urandom_range(9) < 3)
        begin
            it.cell_x = CELL_W'($urandom_range(3));
            it.cell_y = CELL_W'($urandom_range(3));
        end
        else
        begin
            it.cell_x = CELL_W'($urandom_range(15));
            it.cell_y = CELL_W'($urandom_range(15));
        end
        it.heading        = 2'($urandom_range(3));
        it.wall_side      = 1'($urandom_range(1));
        it.query_known    = 1'($urandom_range(1));
        it.right_reading  = pick_reading(side_limit);
        it.center_reading = pick_reading(front_limit);
        it.left_reading   = pick_reading(side_limit);
        return it;
    endfunction

    task automatic send_row(input stim_row_t row);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        pinned_answers.push_back(row);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= row.item.opcode;
        s_axis_tdata  <= pack_fields(row.item);
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic set_thresholds(input logic [SENSOR_W-1:0] side_val,
                                  input logic [SENSOR_W-1:0] front_val);
        cfg_valid <= 1'b1;
        cfg_index <= REG_SIDE_THRESHOLD;
        cfg_data  <= side_val;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= REG_FRONT_THRESHOLD;
        cfg_data  <= front_val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (answers_due.size() != 0) @(posedge clk);
    endtask

    // input transfers feed the model
    always @(posedge clk)
    begin
        stim_row_t pin;
        item_t     it;
        logic      answer;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            pin               = pinned_answers.pop_front();
            it.opcode         = s_axis_tuser;
            it.cell_x         = s_axis_tdata[3:0];
            it.cell_y         = s_axis_tdata[7:4];
            it.heading        = s_axis_tdata[9:8];
            it.wall_side      = s_axis_tdata[10];
            it.query_known    = s_axis_tdata[11];
            it.right_reading  = s_axis_tdata[23:12];
            it.center_reading = s_axis_tdata[35:24];
            it.left_reading   = s_axis_tdata[47:36];
            answer = apply_map_item(it);
            answers_due.push_back({7'd0, pin.pinned ? pin.answer : answer});
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SIDE_THRESHOLD:  side_limit = cfg_data;
                REG_FRONT_THRESHOLD: front_limit = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        logic [7:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (answers_due.size() == 0)
            begin
                $display("%0t: answer with none pending, expected none, actual %h",
                         $time, m_axis_tdata);
                mismatch_count++;
            end
            else
            begin
                want = answers_due.pop_front();
                if (m_axis_tdata !== want)
                begin
                    $display("%0t: answer mismatch, expected %h, actual %h",
                             $time, want, m_axis_tdata);
                    mismatch_count++;
                end
            end
        end
    end

    // receiver: random stalls, or a long hold-off while the count runs down
    always @(posedge clk)
    begin
        if (rx_hold_left != 0)
        begin
            m_axis_tready <= 1'b0;
            rx_hold_left  <= rx_hold_left - 1;
        end
        else if (rx_hold_start && !rx_hold_done)
        begin
            m_axis_tready <= 1'b0;
            rx_hold_left  <= 299;
            rx_hold_done  <= 1'b1;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        stim_row_t directed[$];
        stim_row_t row;
        logic [SENSOR_W-1:0] side_val;
        logic [SENSOR_W-1:0] front_val;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // cleared map, then border cells and readings on the thresholds
        directed.push_back('{make_item(OP_QUERY, 0, 0, DIR_NORTH, 0, 0, 0, 0, 0), 1, 0});
        directed.push_back('{make_item(OP_QUERY, 15, 15, DIR_NORTH, 1, 1, 0, 0, 0), 1, 0});
        directed.push_back('{make_item(OP_SENSE, 0, 0, DIR_NORTH, 0, 0, 4095, 4095, 4095),
                             1, 0});
        directed.push_back('{make_item(OP_QUERY, 0, 0, DIR_NORTH, 0, 0, 0, 0, 0), 0, 0});
        directed.push_back('{make_item(OP_QUERY, 0, 0, DIR_NORTH, 1, 1, 0, 0, 0), 0, 0});
        directed.push_back('{make_item(OP_SENSE, 0, 0, DIR_SOUTH, 0, 0, 100, 150, 100), 1, 0});
        directed.push_back('{make_item(OP_SENSE, 15, 15, DIR_EAST, 0, 0, 101, 151, 0), 1, 0});
        directed.push_back('{make_item(OP_QUERY, 15, 15, DIR_NORTH, 1, 0, 0, 0, 0), 0, 0});
        directed.push_back('{make_item(OP_QUERY, 15, 14, DIR_NORTH, 0, 0, 0, 0, 0), 0, 0});
        directed.push_back('{make_item(OP_QUERY, 15, 15, DIR_NORTH, 0, 1, 0, 0, 0), 0, 0});
        directed.push_back('{make_item(OP_QUERY, 15, 15, DIR_NORTH, 0, 0, 0, 0, 0), 0, 0});
        directed.push_back('{make_item(OP_SENSE, 15, 0, DIR_WEST, 0, 0, 0, 4095, 4095), 1, 0});
        directed.push_back('{make_item(OP_QUERY, 14, 0, DIR_NORTH, 1, 0, 0, 0, 0), 0, 0});
        directed.push_back('{make_item(OP_QUERY, 15, 0, DIR_NORTH, 0, 1, 0, 0, 0), 0, 0});
        directed.push_back('{make_item(OP_QUERY, 15, 0, DIR_NORTH, 0, 0, 0, 0, 0), 0, 0});
        directed.push_back('{make_item(OP_INSERT, 7, 9, DIR_NORTH, 0, 0, 0, 0, 0), 1, 0});
        directed.push_back('{make_item(OP_INSERT, 0, 15, DIR_NORTH, 1, 0, 0, 0, 0), 1, 0});
        directed.push_back('{make_item(OP_QUERY, 7, 9, DIR_NORTH, 0, 0, 0, 0, 0), 0, 0});
        directed.push_back('{make_item(OP_QUERY, 0, 15, DIR_NORTH, 1, 0, 0, 0, 0), 0, 0});
        directed.push_back('{make_item(OP_QUERY, 0, 15, DIR_NORTH, 1, 1, 0, 0, 0), 0, 0});
        directed.push_back('{make_item(OP_UNUSED, 15, 15, DIR_WEST, 1, 1, 4095, 4095, 4095),
                             1, 0});
        directed.push_back('{make_item(OP_SENSE, 8, 8, DIR_NORTH, 0, 0, 0, 0, 0), 1, 0});
        directed.push_back('{make_item(OP_QUERY, 8, 8, DIR_NORTH, 0, 1, 0, 0, 0), 0, 0});
        directed.push_back('{make_item(OP_QUERY, 15, 15, DIR_WEST, 1, 1, 4095, 4095, 4095),
                             0, 0});
        foreach (directed[i])
            send_row(directed[i]);
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    side_val  = '0;
                    front_val = '0;
                end
                1:
                begin
                    side_val  = '1;
                    front_val = '1;
                end
                2:
                begin
                    side_val  = '1;
                    front_val = '0;
                end
                3:
                begin
                    side_val  = SENSOR_W'($urandom_range(4095));
                    front_val = SENSOR_W'($urandom_range(4095));
                end
                4:
                begin
                    side_val  = '0;
                    front_val = '1;
                end
                default:
                begin
                    side_val  = SIDE_THRESHOLD_RESET;
                    front_val = FRONT_THRESHOLD_RESET;
                end
            endcase
            set_thresholds(side_val, front_val);
            // one phase runs back to back on both sides
            tx_idle_pct <= (phase == 3) ? 0 : 6;
            rx_idle_pct <= (phase == 3) ? 0 : 6;
            for (int n = 0; n < 200; n++)
            begin
                if (phase == 1 && n == 40)
                    rx_hold_start <= 1'b1;
                row.item   = random_item();
                row.pinned = 1'b0;
                row.answer = 1'b0;
                send_row(row);
            end
            drain();
        end

        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && answers_due.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
